// ===== rtl/json_string_unescape_core_defines.svh =====
`ifndef JSON_STRING_UNESCAPE_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_CORE_DEFINES_SVH

// Property checked while the block is out of reset
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that also spans the reset window
`define JSU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;
  localparam int unsigned QCW    = 3;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  localparam logic [15:0] CP_TWO_BYTE = 16'h0080;
  localparam logic [15:0] CP_THREE_BYTE = 16'h0800;
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] CONT = 8'h80;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_STR  = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_NO_OPEN     = 3'd1,
    ERR_BAD_ESCAPE  = 3'd2,
    ERR_BAD_HEX     = 3'd3,
    ERR_UNTERM_STR  = 3'd4,
    ERR_UNTERM_ESC  = 3'd5,
    ERR_UNTERM_UNI  = 3'd6
  } err_t;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_ERR   = 2'd2,
    OP_UTF8  = 2'd3
  } op_t;

  // One queued command: a byte, a close, an error or a code point to encode
  typedef struct packed {
    op_t         op;
    logic [15:0] val;
    err_t        err;
  } cmd_t;

endpackage

// ===== rtl/json_string_unescape_core.sv =====
// JSON string unescape core.
// in_ channel: one beat per input byte; in_tuser set marks end of input
// (in_tdata then ignored). out_ channel: decoded bytes, a close marker or
// an error, kind on out_tuser, out_tlast on the final beat caused by one
// input beat. The front decoder classifies each accepted beat in the cycle
// it arrives and queues at most one command; the back end expands a \u
// command into one to three UTF-8 beats, one per cycle while the receiver
// takes them, from a four-entry command queue into a registered output stage.
// Each result beat passes through the command queue, then the output stage.
// Throughput: one input beat per cycle while the queue has room, one output
// beat per cycle while out_tready is high; a \uXXXX escape spends six input
// beats for at most three output beats, so a steady stream keeps pace.
// Reset (rst_n low, synchronous) returns the decoder to awaiting an opening
// quote and empties the queue and output stage. When the receiver holds off
// out_tready, the output beat holds, the queue fills and in_tready falls.
module json_string_unescape_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,  // [7:0] in_byte
  input  logic        in_tuser,  // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // [7:0] out_byte, [10:8] error_code, [15:11] zero
  output logic [1:0]  out_tuser, // [1:0] out_kind
  output logic        out_tlast  // last_of_run
);

  logic           q_full, push, pop, head_valid;
  jsu_pkg::cmd_t  push_cmd, head_cmd;
  jsu_pkg::kind_t kind;
  jsu_pkg::err_t  err;
  logic [7:0]     obyte;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_end   (in_tuser),
    .in_byte  (in_tdata),
    .q_full   (q_full),
    .in_ready (in_tready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  jsu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (kind),
    .out_byte   (obyte),
    .out_err    (err),
    .out_last   (out_tlast)
  );

  assign out_tdata = {5'd0, err, obyte};
  assign out_tuser = kind;

endmodule

// ===== rtl/jsu_front.sv =====
module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_end,
  input  logic [7:0]    in_byte,
  input  logic          q_full,
  output logic          in_ready,
  output logic          push,
  output jsu_pkg::cmd_t push_cmd
);

  jsu_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]      hex_cnt_r, hex_cnt_nxt;
  logic [11:0]     cp_r, cp_nxt;
  jsu_pkg::err_t   fail;
  logic            accept;
  logic [4:0]      hex;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hex      = hex_digit(in_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= jsu_pkg::PH_IDLE;
      hex_cnt_r <= 2'd0;
      cp_r      <= 12'd0;
    end else begin
      phase_r   <= phase_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      cp_r      <= cp_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    hex_cnt_nxt = hex_cnt_r;
    cp_nxt      = cp_r;
    fail        = jsu_pkg::ERR_NONE;
    push        = 1'b0;
    push_cmd    = '{op: jsu_pkg::OP_BYTE, val: 16'd0, err: jsu_pkg::ERR_NONE};
    if (accept) begin
      unique case (phase_r)
        jsu_pkg::PH_IDLE: begin
          if (in_end || in_byte != jsu_pkg::CH_QUOTE) fail = jsu_pkg::ERR_NO_OPEN;
          else phase_nxt = jsu_pkg::PH_STR;
        end
        jsu_pkg::PH_STR: begin
          priority if (in_end) begin
            fail = jsu_pkg::ERR_UNTERM_STR;
          end else if (in_byte == jsu_pkg::CH_QUOTE) begin
            push         = 1'b1;
            push_cmd.op  = jsu_pkg::OP_CLOSE;
            phase_nxt    = jsu_pkg::PH_IDLE;
          end else if (in_byte == jsu_pkg::CH_BSLASH) begin
            phase_nxt = jsu_pkg::PH_ESC;
          end else begin
            push         = 1'b1;
            push_cmd.val = {8'd0, in_byte};
          end
        end
        jsu_pkg::PH_ESC: begin
          if (in_end) begin
            fail = jsu_pkg::ERR_UNTERM_ESC;
          end else begin
            push      = 1'b1;
            phase_nxt = jsu_pkg::PH_STR;
            unique case (in_byte)
              jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
                push_cmd.val = {8'd0, in_byte};
              jsu_pkg::CH_B: push_cmd.val = 16'h0008;
              jsu_pkg::CH_F: push_cmd.val = 16'h000C;
              jsu_pkg::CH_N: push_cmd.val = 16'h000A;
              jsu_pkg::CH_R: push_cmd.val = 16'h000D;
              jsu_pkg::CH_T: push_cmd.val = 16'h0009;
              jsu_pkg::CH_U: begin
                push        = 1'b0;
                phase_nxt   = jsu_pkg::PH_HEX;
                hex_cnt_nxt = 2'd0;
                cp_nxt      = 12'd0;
              end
              default: begin
                push = 1'b0;
                fail = jsu_pkg::ERR_BAD_ESCAPE;
              end
            endcase
          end
        end
        jsu_pkg::PH_HEX: begin
          priority if (in_end) begin
            fail = jsu_pkg::ERR_UNTERM_UNI;
          end else if (!hex[4]) begin
            fail = jsu_pkg::ERR_BAD_HEX;
          end else if (hex_cnt_r == 2'd3) begin
            push         = 1'b1;
            push_cmd.op  = jsu_pkg::OP_UTF8;
            push_cmd.val = {cp_r, hex[3:0]};
            hex_cnt_nxt  = 2'd0;
            cp_nxt       = 12'd0;
            phase_nxt    = jsu_pkg::PH_STR;
          end else begin
            cp_nxt      = {cp_r[7:0], hex[3:0]};
            hex_cnt_nxt = hex_cnt_r + 2'd1;
          end
        end
        default: phase_nxt = jsu_pkg::PH_IDLE;
      endcase
      if (fail != jsu_pkg::ERR_NONE) begin
        push         = 1'b1;
        push_cmd.op  = jsu_pkg::OP_ERR;
        push_cmd.val = 16'd0;
        push_cmd.err = fail;
        phase_nxt    = jsu_pkg::PH_IDLE;
        hex_cnt_nxt  = 2'd0;
        cp_nxt       = 12'd0;
      end
    end
  end

endmodule

// ===== rtl/jsu_queue.sv =====
module jsu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output jsu_pkg::cmd_t head_cmd
);

  jsu_pkg::cmd_t                  entries_r [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QAW-1:0]        wr_ptr_r, rd_ptr_r;
  logic [jsu_pkg::QCW-1:0]        count_r, count_nxt;

  assign full       = (count_r == jsu_pkg::QCW'(jsu_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/jsu_back.sv =====
module jsu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  jsu_pkg::cmd_t  head_cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output jsu_pkg::kind_t out_kind,
  output logic [7:0]     out_byte,
  output jsu_pkg::err_t  out_err,
  output logic           out_last
);

  logic [1:0]     seq_r;
  logic [1:0]     n_last;
  logic           load, is_last;
  logic [7:0]     byte_sel;
  logic [15:0]    cp;
  jsu_pkg::kind_t kind_sel;

  logic           valid_r;
  jsu_pkg::kind_t kind_r;
  logic [7:0]     byte_r;
  jsu_pkg::err_t  err_r;
  logic           last_r;

  assign cp = head_cmd.val;

  always_comb begin
    n_last   = 2'd0;
    byte_sel = 8'd0;
    kind_sel = jsu_pkg::KIND_DATA;
    unique case (head_cmd.op)
      jsu_pkg::OP_BYTE:  byte_sel = cp[7:0];
      jsu_pkg::OP_CLOSE: kind_sel = jsu_pkg::KIND_CLOSE;
      jsu_pkg::OP_ERR:   kind_sel = jsu_pkg::KIND_ERR;
      jsu_pkg::OP_UTF8: begin
        priority if (cp < jsu_pkg::CP_TWO_BYTE) begin
          byte_sel = cp[7:0];
        end else if (cp < jsu_pkg::CP_THREE_BYTE) begin
          n_last   = 2'd1;
          byte_sel = (seq_r == 2'd0) ? (jsu_pkg::LEAD2 | {3'd0, cp[10:6]})
                                     : (jsu_pkg::CONT | {2'd0, cp[5:0]});
        end else begin
          n_last = 2'd2;
          unique case (seq_r)
            2'd0:    byte_sel = jsu_pkg::LEAD3 | {4'd0, cp[15:12]};
            2'd1:    byte_sel = jsu_pkg::CONT | {2'd0, cp[11:6]};
            default: byte_sel = jsu_pkg::CONT | {2'd0, cp[5:0]};
          endcase
        end
      end
      default: kind_sel = jsu_pkg::KIND_ERR;
    endcase
  end

  assign is_last = (seq_r == n_last);
  assign load    = head_valid && (!valid_r || out_ready);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      seq_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        seq_r   <= is_last ? 2'd0 : seq_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_sel;
      byte_r <= byte_sel;
      err_r  <= head_cmd.err;
      last_r <= is_last;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_byte  = byte_r;
  assign out_err   = err_r;
  assign out_last  = last_r;

endmodule

// ===== rtl/jsu_checker.sv =====
`include "json_string_unescape_core_defines.svh"

module jsu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  logic [18:0] out_beat;
  logic        stall;
  logic        not_data;
  logic        fields_ok;

  assign out_beat  = {out_tlast, out_tuser, out_tdata};
  assign stall     = out_tvalid && !out_tready;
  assign not_data  = (out_tuser != jsu_pkg::KIND_DATA);
  // error code set exactly on error beats, byte clear on close and error beats
  assign fields_ok = ((out_tuser == jsu_pkg::KIND_ERR) == (out_tdata[10:8] != 3'd0)) &&
                     (!not_data || (out_tdata[7:0] == 8'd0));

  `JSU_ASSERT_RST(a_rst_idle, !rst_n |=> !out_tvalid, "output valid after reset")

  `JSU_ASSERT(a_hold, stall |=> out_tvalid && $stable(out_beat), "stalled beat changed")

  `JSU_ASSERT(a_single_last, out_tvalid && not_data |-> out_tlast, "close or error without last")

  `JSU_ASSERT(a_err_code, out_tvalid |-> fields_ok, "error code or byte inconsistent with kind")

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== test/tb_json_string_unescape_core.sv =====
module tb_json_string_unescape_core;
  import jsu_pkg::*;

  localparam int ITEMS   = 400;
  localparam int QUIET   = 1000;
  localparam int NSCRIPT = 28;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ob;
    err_t       err;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] ch;
    logic       typed;
    kind_t      kind;
    logic [7:0] obyte;
    err_t       err;
  } step_t;

  // Directed beats; typed rows carry their single result, the rest go to the decoder copy
  localparam step_t SCRIPT [0:NSCRIPT-1] = '{
    '{1'b0, "x",       1'b1, KIND_ERR,   8'h00, ERR_NO_OPEN},
    '{1'b1, 8'h00,     1'b1, KIND_ERR,   8'h00, ERR_NO_OPEN},
    '{1'b0, CH_QUOTE,  1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b0, 8'h00,     1'b1, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b0, 8'hFF,     1'b1, KIND_DATA,  8'hFF, ERR_NONE},
    '{1'b0, CH_BSLASH, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b0, CH_U,      1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b0, "F",       1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b0, "f",       1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b0, "f",       1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b0, "F",       1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b0, CH_QUOTE,  1'b1, KIND_CLOSE, 8'h00, ERR_NONE},
    '{1'b0, CH_QUOTE,  1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b0, CH_BSLASH, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b0, "z",       1'b1, KIND_ERR,   8'h00, ERR_BAD_ESCAPE},
    '{1'b0, CH_QUOTE,  1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b0, CH_BSLASH, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b0, CH_U,      1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b0, "g",       1'b1, KIND_ERR,   8'h00, ERR_BAD_HEX},
    '{1'b0, CH_QUOTE,  1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b0, CH_BSLASH, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b0, CH_U,      1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b1, 8'h00,     1'b1, KIND_ERR,   8'h00, ERR_UNTERM_UNI},
    '{1'b0, CH_QUOTE,  1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b1, 8'h00,     1'b1, KIND_ERR,   8'h00, ERR_UNTERM_STR},
    '{1'b0, CH_QUOTE,  1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b0, CH_BSLASH, 1'b0, KIND_DATA,  8'h00, ERR_NONE},
    '{1'b1, 8'h00,     1'b1, KIND_ERR,   8'h00, ERR_UNTERM_ESC}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;  // [7:0] in_byte
  logic        in_tuser;  // [0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata; // [7:0] out_byte, [10:8] error_code, [15:11] zero
  logic [1:0]  out_tuser; // [1:0] out_kind
  logic        out_tlast;

  json_string_unescape_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Decoder copy and the decoded beats still owed by the block
  phase_t      dec_phase;
  logic [1:0]  dec_hex_n;
  logic [15:0] dec_cp;
  beat_t       fresh[$];
  beat_t       owed[$];

  int  mismatches;
  int  quiet;
  int  sent;
  bit  calm_in;
  bit  calm_out;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic int hex_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  task automatic add_beat(input kind_t k, input logic [7:0] b, input err_t e);
    beat_t r;
    r.kind = k;
    r.ob   = b;
    r.err  = e;
    r.last = 1'b0;
    fresh.insert(fresh.size(), r);
  endtask

  task automatic abort_string(input err_t e);
    add_beat(KIND_ERR, 8'h00, e);
    dec_phase = PH_IDLE;
    dec_hex_n = '0;
    dec_cp    = '0;
  endtask

  // Work out the beats one accepted input beat causes and advance the decoder copy
  task automatic decode_beat(input logic at_end, input logic [7:0] c);
    int         d;
    logic [7:0] lit;
    logic [15:0] cp;
    fresh.delete();
    case (dec_phase)
      PH_IDLE: begin
        if (at_end || c != CH_QUOTE) abort_string(ERR_NO_OPEN);
        else dec_phase = PH_STR;
      end
      PH_STR: begin
        if (at_end) begin
          abort_string(ERR_UNTERM_STR);
        end else if (c == CH_QUOTE) begin
          add_beat(KIND_CLOSE, 8'h00, ERR_NONE);
          dec_phase = PH_IDLE;
        end else if (c == CH_BSLASH) begin
          dec_phase = PH_ESC;
        end else begin
          add_beat(KIND_DATA, c, ERR_NONE);
        end
      end
      PH_ESC: begin
        if (at_end) begin
          abort_string(ERR_UNTERM_ESC);
        end else if (c == CH_U) begin
          dec_phase = PH_HEX;
          dec_hex_n = '0;
          dec_cp    = '0;
        end else if (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R,
                               CH_T}) begin
          case (c)
            CH_B:    lit = 8'h08;
            CH_F:    lit = 8'h0C;
            CH_N:    lit = 8'h0A;
            CH_R:    lit = 8'h0D;
            CH_T:    lit = 8'h09;
            default: lit = c;
          endcase
          add_beat(KIND_DATA, lit, ERR_NONE);
          dec_phase = PH_STR;
        end else begin
          abort_string(ERR_BAD_ESCAPE);
        end
      end
      default: begin
        d = hex_of(c);
        if (at_end) begin
          abort_string(ERR_UNTERM_UNI);
        end else if (d < 0) begin
          abort_string(ERR_BAD_HEX);
        end else begin
          dec_cp = {dec_cp[11:0], 4'(d)};
          if (dec_hex_n == 2'd3) begin
            cp = dec_cp;
            if (cp < CP_TWO_BYTE) begin
              add_beat(KIND_DATA, cp[7:0], ERR_NONE);
            end else if (cp < CP_THREE_BYTE) begin
              add_beat(KIND_DATA, LEAD2 | {3'b000, cp[10:6]}, ERR_NONE);
              add_beat(KIND_DATA, CONT | {2'b00, cp[5:0]}, ERR_NONE);
            end else begin
              add_beat(KIND_DATA, LEAD3 | {4'h0, cp[15:12]}, ERR_NONE);
              add_beat(KIND_DATA, CONT | {2'b00, cp[11:6]}, ERR_NONE);
              add_beat(KIND_DATA, CONT | {2'b00, cp[5:0]}, ERR_NONE);
            end
            dec_phase = PH_STR;
            dec_hex_n = '0;
            dec_cp    = '0;
          end else begin
            dec_hex_n = dec_hex_n + 2'd1;
          end
        end
      end
    endcase
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
  endtask

  task automatic pick_gap(inout bit calm, output int gap);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    if (calm || $urandom_range(0, 3) == 0) gap = 0;
    else gap = $urandom_range(0, 12);
  endtask

  // Drive one beat at the falling edge and hold it until the block takes it
  task automatic send_beat(input logic mode, input logic [7:0] ch, input logic typed,
                           input kind_t k, input logic [7:0] ob, input err_t e);
    int    gap;
    beat_t r;
    pick_gap(calm_in, gap);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = mode ? 8'($urandom) : ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_beat(mode, ch);
    if (typed) begin
      r.kind = k;
      r.ob   = ob;
      r.err  = e;
      r.last = 1'b1;
      owed.insert(owed.size(), r);
    end else begin
      foreach (fresh[i]) owed.insert(owed.size(), fresh[i]);
    end
    sent++;
    @(negedge clk);
  endtask

  task automatic feed(input logic mode, input logic [7:0] ch);
    send_beat(mode, ch, 1'b0, KIND_DATA, 8'h00, ERR_NONE);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (owed.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'("0") + 8'(v);
    return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(v - 4'd10);
  endfunction

  function automatic logic [15:0] pick_cp();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 'h7F));
      1:       return 16'($urandom_range('h80, 'h7FF));
      2:       return 16'($urandom_range('h800, 'hFFFF));
      default: begin
        case ($urandom_range(0, 5))
          0:       return 16'h0000;
          1:       return 16'h007F;
          2:       return 16'h0080;
          3:       return 16'h07FF;
          4:       return 16'h0800;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // Backslash, u, then the leading digits of cp
  task automatic feed_unicode(input logic [15:0] cp, input int digits);
    feed(1'b0, CH_BSLASH);
    feed(1'b0, CH_U);
    for (int i = 0; i < digits; i++) feed(1'b0, hex_char(cp[15 - 4*i -: 4]));
  endtask

  task automatic feed_noise();
    int         n;
    logic [7:0] c;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom);
      if ($urandom_range(0, 3) == 0) feed(1'b1, c);
      else feed(1'b0, c);
    end
  endtask

  // One string literal with random body and a random, mostly proper, ending
  task automatic feed_string();
    int         n;
    logic [7:0] c;
    feed(1'b0, CH_QUOTE);
    n = $urandom_range(0, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          do c = 8'($urandom); while (c == CH_QUOTE || c == CH_BSLASH);
          feed(1'b0, c);
        end
        5, 6: begin
          case ($urandom_range(0, 7))
            0:       c = CH_QUOTE;
            1:       c = CH_BSLASH;
            2:       c = CH_SLASH;
            3:       c = CH_B;
            4:       c = CH_F;
            5:       c = CH_N;
            6:       c = CH_R;
            default: c = CH_T;
          endcase
          feed(1'b0, CH_BSLASH);
          feed(1'b0, c);
        end
        default: feed_unicode(pick_cp(), 4);
      endcase
    end
    case ($urandom_range(0, 19))
      15: feed(1'b1, 8'($urandom));
      16: begin
        do c = 8'($urandom);
        while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
        feed(1'b0, CH_BSLASH);
        feed(1'b0, c);
      end
      17: begin
        feed(1'b0, CH_BSLASH);
        feed(1'b1, 8'($urandom));
      end
      18: begin
        do c = 8'($urandom); while (hex_of(c) >= 0);
        feed_unicode(pick_cp(), $urandom_range(0, 3));
        feed(1'b0, c);
      end
      19: begin
        feed_unicode(pick_cp(), $urandom_range(0, 3));
        feed(1'b1, 8'($urandom));
      end
      default: feed(1'b0, CH_QUOTE);
    endcase
  endtask

  task automatic check_beat();
    beat_t w;
    if (owed.size() == 0) begin
      report("beat with nothing owed, kind", int'(out_tuser), 0);
      return;
    end
    w = owed.pop_front();
    if (out_tuser !== w.kind)          report("kind", int'(out_tuser), int'(w.kind));
    if (out_tdata[7:0] !== w.ob)       report("byte", int'(out_tdata[7:0]), int'(w.ob));
    if (out_tdata[10:8] !== w.err)     report("error", int'(out_tdata[10:8]), int'(w.err));
    if (out_tdata[15:11] !== 5'b00000) report("pad", int'(out_tdata[15:11]), 0);
    if (out_tlast !== w.last)          report("last", int'(out_tlast), int'(w.last));
  endtask

  // Check results and watch for a stalled run
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_beat();
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet = quiet + 1;
      if (quiet >= QUIET) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Result side: stall for a random gap before taking each beat
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    @(negedge clk);
    forever begin
      pick_gap(calm_out, gap);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int strings;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tuser   = 1'b0;
    mismatches = 0;
    quiet      = 0;
    sent       = 0;
    strings    = 0;
    calm_in    = 1'b0;
    calm_out   = 1'b0;
    dec_phase  = PH_IDLE;
    dec_hex_n  = '0;
    dec_cp     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NSCRIPT; i++)
      send_beat(SCRIPT[i].mode, SCRIPT[i].ch, SCRIPT[i].typed, SCRIPT[i].kind,
                SCRIPT[i].obyte, SCRIPT[i].err);
    drain();

    while (sent < NSCRIPT + ITEMS) begin
      if ($urandom_range(0, 5) == 0) feed_noise();
      feed_string();
      strings++;
      // hold the sender until the output side has caught up
      if (strings % 20 == 0) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
